// ===== rtl/core/olist_pkg.sv =====
// ----------------------------------------------------------------------------
// olist_pkg: shared types and constants for the ordered list engine
// Holds list sizing, command and status codes, controller states and the
// command/status bundles exchanged between controller and datapath.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package olist_pkg;

  // List sizing
  localparam int CAPACITY    = 16;
  localparam int MAX_RESULTS = 16;
  localparam int CNT_W       = $clog2(CAPACITY + 1);
  localparam int IDX_W       = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

  // Field widths
  localparam int CMD_W    = 3;
  localparam int VALUE_W  = 32;
  localparam int POS_W    = 4;
  localparam int STATUS_W = 2;
  localparam int LEN_W    = 5;

  // Command codes
  typedef enum logic [CMD_W-1:0] {
    CMD_INS_HEAD = 3'd0,
    CMD_INS_TAIL = 3'd1,
    CMD_DEL_POS  = 3'd2,
    CMD_DEL_TAIL = 3'd3,
    CMD_DEL_HEAD = 3'd4,
    CMD_SEARCH   = 3'd5,
    CMD_LIST     = 3'd6
  } olist_cmd_t;

  // Result status codes
  typedef enum logic [STATUS_W-1:0] {
    STAT_OK      = 2'd0,
    STAT_EMPTY   = 2'd1,
    STAT_MISSING = 2'd2,
    STAT_FULL    = 2'd3
  } olist_status_t;

  // Controller states
  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_LIST
  } olist_state_t;

  // Controller to datapath commands
  typedef struct packed {
    logic load;       // latch an accepted request
    logic exec;       // apply the request and emit its single result (none for an unused code)
    logic list_emit;  // emit the current entry and advance the list pointer
  } olist_ctl_t;

  // Datapath to controller status
  typedef struct packed {
    logic out_free;   // output register can take a result this cycle
    logic do_list;    // latched request lists a non-empty list
    logic list_last;  // current list entry is the final one to send
  } olist_sts_t;

endpackage

// ===== rtl/core/olist_ctrl.sv =====
// ----------------------------------------------------------------------------
// olist_ctrl: request sequencer of the ordered list engine
// Accepts one request at a time, triggers the single-result edit or search,
// and steps the datapath through the entries of a list request.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module olist_ctrl
  import olist_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  olist_sts_t sts,
  output olist_ctl_t ctl
);

  olist_state_t state_r, state_nxt;

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_tvalid) state_nxt = S_EXEC;
      end
      S_EXEC: begin
        if (sts.do_list) state_nxt = S_LIST;
        else if (sts.out_free) state_nxt = S_IDLE;
      end
      S_LIST: begin
        if (sts.out_free && sts.list_last) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    in_tready     = 1'b0;
    ctl.load      = 1'b0;
    ctl.exec      = 1'b0;
    ctl.list_emit = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_tready = 1'b1;
        ctl.load  = in_tvalid;
      end
      S_EXEC: begin
        ctl.exec = !sts.do_list && sts.out_free;
      end
      S_LIST: begin
        ctl.list_emit = sts.out_free;
      end
      default: ;
    endcase
  end

  // State register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// ===== rtl/core/olist_dp.sv =====
// ----------------------------------------------------------------------------
// olist_dp: entry cells and result register of the ordered list engine
// Each entry cell loads its neighbor, the new value or itself in one step;
// a search compares every cell at once. Results sit in an output register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module olist_dp
  import olist_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  olist_ctl_t          ctl,
  output olist_sts_t          sts,
  input  logic [CMD_W-1:0]    in_cmd,
  input  logic [VALUE_W-1:0]  in_value,
  input  logic [POS_W-1:0]    in_position,
  input  logic                out_tready,
  output logic                out_valid,
  output logic [STATUS_W-1:0] out_status,
  output logic                out_found,
  output logic [VALUE_W-1:0]  out_entry_value,
  output logic                out_last,
  output logic [LEN_W-1:0]    out_length
);

  // Latched request
  olist_cmd_t          cmd_r;
  logic [VALUE_W-1:0]  value_r;
  logic [POS_W-1:0]    pos_r;

  // List state
  logic [VALUE_W-1:0]  entries_r [CAPACITY];
  logic [VALUE_W-1:0]  entries_nxt [CAPACITY];
  logic [CNT_W-1:0]    count_r, count_nxt;
  logic [IDX_W-1:0]    idx_r, idx_nxt;

  // Output register
  logic                out_valid_r, out_valid_nxt;
  logic [STATUS_W-1:0] out_status_r, out_status_nxt;
  logic                out_found_r, out_found_nxt;
  logic [VALUE_W-1:0]  out_value_r, out_value_nxt;
  logic                out_last_r, out_last_nxt;
  logic [LEN_W-1:0]    out_length_r, out_length_nxt;

  logic                list_empty;
  logic                list_full;
  logic                pos_bad;
  logic                hit;
  logic [VALUE_W-1:0]  cur_entry;
  olist_status_t       stat;

  assign list_empty = (count_r == '0);
  assign list_full  = (count_r == CNT_W'(CAPACITY));
  assign pos_bad    = (32'(pos_r) >= 32'(count_r));
  assign cur_entry  = entries_r[idx_r];

  // Status toward the controller
  assign sts.out_free  = !out_valid_r || out_tready;
  assign sts.do_list   = (cmd_r == CMD_LIST) && !list_empty;
  assign sts.list_last = ((CNT_W'(idx_r) + CNT_W'(1)) == count_r) ||
                         (32'(idx_r) == MAX_RESULTS - 1);

  // Compare every valid cell against the search value
  always_comb begin
    hit = 1'b0;
    for (int i = 0; i < CAPACITY; i++) begin
      if ((32'(i) < 32'(count_r)) && (entries_r[i] == value_r)) hit = 1'b1;
    end
  end

  // Edit the cells and the count for a single-result request
  always_comb begin
    for (int i = 0; i < CAPACITY; i++) entries_nxt[i] = entries_r[i];
    count_nxt = count_r;
    stat      = STAT_OK;
    if (ctl.exec) begin
      unique case (cmd_r) inside
        CMD_INS_HEAD: begin
          if (list_full) begin
            stat = STAT_FULL;
          end else begin
            entries_nxt[0] = value_r;
            for (int i = 1; i < CAPACITY; i++) entries_nxt[i] = entries_r[i-1];
            count_nxt = count_r + CNT_W'(1);
          end
        end
        CMD_INS_TAIL: begin
          if (list_full) begin
            stat = STAT_FULL;
          end else begin
            for (int i = 0; i < CAPACITY; i++) begin
              if (32'(i) == 32'(count_r)) entries_nxt[i] = value_r;
            end
            count_nxt = count_r + CNT_W'(1);
          end
        end
        CMD_DEL_POS: begin
          if (list_empty) begin
            stat = STAT_EMPTY;
          end else if (pos_bad) begin
            stat = STAT_MISSING;
          end else begin
            for (int i = 0; i < CAPACITY - 1; i++) begin
              if (32'(i) >= 32'(pos_r)) entries_nxt[i] = entries_r[i+1];
            end
            count_nxt = count_r - CNT_W'(1);
          end
        end
        CMD_DEL_TAIL: begin
          if (list_empty) stat = STAT_EMPTY;
          else count_nxt = count_r - CNT_W'(1);
        end
        CMD_DEL_HEAD: begin
          if (list_empty) begin
            stat = STAT_EMPTY;
          end else begin
            for (int i = 0; i < CAPACITY - 1; i++) entries_nxt[i] = entries_r[i+1];
            count_nxt = count_r - CNT_W'(1);
          end
        end
        CMD_SEARCH, CMD_LIST: begin
          if (list_empty) stat = STAT_EMPTY;
        end
        default: ;
      endcase
    end
  end

  // Load the output register and step the list pointer
  always_comb begin
    out_valid_nxt  = out_valid_r && !out_tready;
    out_status_nxt = out_status_r;
    out_found_nxt  = out_found_r;
    out_value_nxt  = out_value_r;
    out_last_nxt   = out_last_r;
    out_length_nxt = out_length_r;
    idx_nxt        = idx_r;
    if (ctl.load) begin
      idx_nxt = '0;
    end
    if (ctl.exec && (cmd_r <= CMD_LIST)) begin
      out_valid_nxt  = 1'b1;
      out_status_nxt = stat;
      out_found_nxt  = (cmd_r == CMD_SEARCH) && !list_empty && hit;
      out_value_nxt  = '0;
      out_last_nxt   = 1'b1;
      out_length_nxt = LEN_W'(count_nxt);
    end
    if (ctl.list_emit) begin
      out_valid_nxt  = 1'b1;
      out_status_nxt = STAT_OK;
      out_found_nxt  = 1'b0;
      out_value_nxt  = cur_entry;
      out_last_nxt   = sts.list_last;
      out_length_nxt = LEN_W'(count_r);
      idx_nxt        = idx_r + IDX_W'(1);
    end
  end

  // Hold the latched request
  always_ff @(posedge clk) begin
    if (ctl.load) begin
      cmd_r   <= olist_cmd_t'(in_cmd);
      value_r <= in_value;
      pos_r   <= in_position;
    end
  end

  // Entry cells and result payload
  always_ff @(posedge clk) begin
    for (int i = 0; i < CAPACITY; i++) entries_r[i] <= entries_nxt[i];
    out_status_r <= out_status_nxt;
    out_found_r  <= out_found_nxt;
    out_value_r  <= out_value_nxt;
    out_last_r   <= out_last_nxt;
    out_length_r <= out_length_nxt;
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      idx_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      count_r     <= count_nxt;
      idx_r       <= idx_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_status      = out_status_r;
  assign out_found       = out_found_r;
  assign out_entry_value = out_value_r;
  assign out_last        = out_last_r;
  assign out_length      = out_length_r;

endmodule

// ===== rtl/core/ordered_list_engine.sv =====
// ----------------------------------------------------------------------------
// ordered_list_engine: ordered list of signed 32-bit values
// Inserts at head or tail, deletes by position, head or tail, searches and
// lists the entries of a list held in shift cells.
//
//   channel | direction | tdata fields (low bit up)                | tuser
//   --------+-----------+------------------------------------------+--------
//   in_     | request   | value[31:0], position[35:32], zero pad   | cmd
//   out_    | result    | found[0], entry_value[32:1],             | status
//           |           | length[37:33], zero pad                  |
//
// A request is accepted in the idle step, then edits or searches the cells in
// the edit step. A list request goes on to the list step and sends one entry
// per cycle while not stalled, from the single read mux on the entry cells.
// Reset clears the list to empty; no clearing pass is needed.
// The result register lets a new request be accepted while a result waits;
// a stalled output holds the sequencer in the edit or list step.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ordered_list_engine
  import olist_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [39:0] in_tdata,   // value[31:0], position[35:32]
  input  logic [2:0]  in_tuser,   // cmd[2:0]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata,  // found[0], entry_value[32:1], length[37:33]
  output logic [1:0]  out_tuser,  // status[1:0]
  output logic        out_tlast
);

  olist_ctl_t          ctl;
  olist_sts_t          sts;
  logic [STATUS_W-1:0] status;
  logic                found;
  logic [VALUE_W-1:0]  entry_value;
  logic [LEN_W-1:0]    length;

  // Sequencer
  olist_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .sts       (sts),
    .ctl       (ctl)
  );

  // Entry cells and result register
  olist_dp u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .ctl             (ctl),
    .sts             (sts),
    .in_cmd          (in_tuser),
    .in_value        (in_tdata[31:0]),
    .in_position     (in_tdata[35:32]),
    .out_tready      (out_tready),
    .out_valid       (out_tvalid),
    .out_status      (status),
    .out_found       (found),
    .out_entry_value (entry_value),
    .out_last        (out_tlast),
    .out_length      (length)
  );

  // Pack the result
  assign out_tdata = {2'b00, length, entry_value, found};
  assign out_tuser = status;

endmodule

// ===== tb/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench: self-checking bench for the ordered list engine
// Drives insert, delete, search and list requests through the request stream,
// predicts every result with a behavioral list model and checks each result
// field by field, under several patterns of sender idling and receiver stall.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;
  import olist_pkg::*;

  localparam logic [CMD_W-1:0] CMD_UNUSED = 3'd7;
  localparam int CYCLE_LIMIT = 200000;
  localparam int HOLD_CYCLES = 150;
  localparam int TAIL_CYCLES = 3 * MAX_RESULTS + 8;
  localparam int PHASE_ITEMS = 20;
  localparam int NUM_ROWS    = 24;

  typedef struct {
    olist_status_t      status;
    logic               found;
    logic [VALUE_W-1:0] entry_value;
    logic               is_last;
    logic [LEN_W-1:0]   length;
  } list_result_t;

  // One directed request; status and length are typed in only where typed is set
  typedef struct {
    logic [CMD_W-1:0]   cmd;
    logic [VALUE_W-1:0] value;
    logic [POS_W-1:0]   pos;
    bit                 typed;
    olist_status_t      status;
    logic [LEN_W-1:0]   length;
  } stim_row_t;

  stim_row_t directed_rows [NUM_ROWS] = '{
    '{CMD_SEARCH,   32'h0000_0005, 4'd0,  1'b1, STAT_EMPTY,   5'd0},
    '{CMD_LIST,     32'h0000_0000, 4'd0,  1'b1, STAT_EMPTY,   5'd0},
    '{CMD_DEL_HEAD, 32'h0000_0000, 4'd0,  1'b1, STAT_EMPTY,   5'd0},
    '{CMD_DEL_TAIL, 32'h0000_0000, 4'd0,  1'b1, STAT_EMPTY,   5'd0},
    '{CMD_DEL_POS,  32'h0000_0000, 4'd15, 1'b1, STAT_EMPTY,   5'd0},
    '{CMD_UNUSED,   32'hFFFF_FFFF, 4'd15, 1'b0, STAT_OK,      5'd0},
    // only entry removed by position zero, by tail and by head
    '{CMD_INS_TAIL, 32'h7FFF_FFFF, 4'd0,  1'b1, STAT_OK,      5'd1},
    '{CMD_DEL_POS,  32'h0000_0000, 4'd0,  1'b1, STAT_OK,      5'd0},
    '{CMD_INS_HEAD, 32'h8000_0000, 4'd0,  1'b1, STAT_OK,      5'd1},
    '{CMD_DEL_TAIL, 32'h0000_0000, 4'd0,  1'b1, STAT_OK,      5'd0},
    '{CMD_INS_HEAD, 32'h7FFF_FFFF, 4'd0,  1'b1, STAT_OK,      5'd1},
    '{CMD_DEL_HEAD, 32'h0000_0000, 4'd0,  1'b1, STAT_OK,      5'd0},
    '{CMD_INS_HEAD, 32'h8000_0000, 4'd0,  1'b1, STAT_OK,      5'd1},
    '{CMD_INS_TAIL, 32'h7FFF_FFFF, 4'd0,  1'b1, STAT_OK,      5'd2},
    '{CMD_INS_HEAD, 32'h0000_0000, 4'd0,  1'b1, STAT_OK,      5'd3},
    '{CMD_INS_TAIL, 32'hFFFF_FFFF, 4'd0,  1'b1, STAT_OK,      5'd4},
    // hit, then miss
    '{CMD_SEARCH,   32'h8000_0000, 4'd0,  1'b1, STAT_OK,      5'd4},
    '{CMD_SEARCH,   32'h1234_5678, 4'd0,  1'b1, STAT_OK,      5'd4},
    // position past the end
    '{CMD_DEL_POS,  32'h0000_0000, 4'd15, 1'b1, STAT_MISSING, 5'd4},
    '{CMD_DEL_POS,  32'h0000_0000, 4'd4,  1'b1, STAT_MISSING, 5'd4},
    '{CMD_LIST,     32'h0000_0000, 4'd0,  1'b0, STAT_OK,      5'd0},
    '{CMD_DEL_POS,  32'h0000_0000, 4'd2,  1'b1, STAT_OK,      5'd3},
    '{CMD_DEL_POS,  32'h0000_0000, 4'd0,  1'b1, STAT_OK,      5'd2},
    '{CMD_LIST,     32'h0000_0000, 4'd0,  1'b0, STAT_OK,      5'd0}
  };

  int idle_pct_by_phase  [4] = '{0, 45, 0, 38};
  int stall_pct_by_phase [4] = '{0, 0, 45, 38};

  logic               clk;
  logic               rst_n;
  logic               in_tvalid;
  logic               in_tready;
  logic [39:0]        in_tdata;   // value[31:0], position[35:32]
  logic [CMD_W-1:0]   in_tuser;   // cmd[2:0]
  logic               out_tvalid;
  logic               out_tready;
  logic [39:0]        out_tdata;  // found[0], entry_value[32:1], length[37:33]
  logic [STATUS_W-1:0] out_tuser; // status[1:0]
  logic               out_tlast;

  // List model and the results it still owes
  logic [VALUE_W-1:0] list_vals [CAPACITY];
  int                 list_len = 0;
  list_result_t       pending_results [$];

  int requests_sent   = 0;
  int results_seen    = 0;
  int refused_inserts = 0;
  int peak_len        = 0;
  int mismatches      = 0;
  int send_idle_pct   = 0;
  int recv_stall_pct  = 0;
  int hold_asks       = 0;
  int hold_seen       = 0;

  ordered_list_engine u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Close up the gap left by a removed entry
  function automatic void drop_entry(input int idx);
    int i;
    for (i = idx; i + 1 < list_len; i++) list_vals[i] = list_vals[i + 1];
    list_len--;
  endfunction

  // Apply one accepted request to the model and queue the results it causes
  function automatic void predict_request(input logic [CMD_W-1:0] cmd,
                                          input logic [VALUE_W-1:0] value,
                                          input logic [POS_W-1:0] pos,
                                          output list_result_t first_res);
    list_result_t res;
    int i;
    int n;
    res = '{STAT_OK, 1'b0, '0, 1'b1, '0};
    first_res = res;
    case (cmd) inside
      CMD_INS_HEAD, CMD_INS_TAIL: begin
        if (list_len >= CAPACITY) begin
          res.status = STAT_FULL;
          refused_inserts++;
        end else begin
          if (cmd == CMD_INS_HEAD) begin
            for (i = list_len; i > 0; i--) list_vals[i] = list_vals[i - 1];
            list_vals[0] = value;
          end else begin
            list_vals[list_len] = value;
          end
          list_len++;
        end
      end
      CMD_DEL_POS: begin
        if (list_len == 0) res.status = STAT_EMPTY;
        else if (int'(pos) >= list_len) res.status = STAT_MISSING;
        else drop_entry(int'(pos));
      end
      CMD_DEL_TAIL: begin
        if (list_len == 0) res.status = STAT_EMPTY;
        else list_len--;
      end
      CMD_DEL_HEAD: begin
        if (list_len == 0) res.status = STAT_EMPTY;
        else drop_entry(0);
      end
      CMD_SEARCH: begin
        if (list_len == 0) res.status = STAT_EMPTY;
        else for (i = 0; i < list_len; i++) if (list_vals[i] == value) res.found = 1'b1;
      end
      CMD_LIST: begin
        // an empty list answers with a single empty status below
        if (list_len == 0) begin
          res.status = STAT_EMPTY;
        end else begin
          n = (list_len < MAX_RESULTS) ? list_len : MAX_RESULTS;
          for (i = 0; i < n; i++) begin
            res.entry_value = list_vals[i];
            res.is_last     = (i == n - 1);
            res.length      = list_len[LEN_W-1:0];
            pending_results.push_back(res);
            if (i == 0) first_res = res;
          end
          return;
        end
      end
      default: return;  // unused code: no result, no change
    endcase
    if (list_len > peak_len) peak_len = list_len;
    res.length = list_len[LEN_W-1:0];
    pending_results.push_back(res);
    first_res = res;
  endfunction

  function automatic logic [VALUE_W-1:0] pick_value();
    case ($urandom_range(9))
      0:       return 32'h7FFF_FFFF;
      1:       return 32'h8000_0000;
      2:       return '0;
      3, 4:    return (list_len > 0) ? list_vals[$urandom_range(list_len - 1)] : $urandom;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [POS_W-1:0] pick_position();
    if (list_len > 0 && $urandom_range(2) != 0) return POS_W'($urandom_range(list_len - 1));
    return POS_W'($urandom_range(15));
  endfunction

  function automatic logic [CMD_W-1:0] pick_delete();
    case ($urandom_range(2))
      0:       return CMD_DEL_POS;
      1:       return CMD_DEL_TAIL;
      default: return CMD_DEL_HEAD;
    endcase
  endfunction

  function automatic logic [CMD_W-1:0] pick_command();
    int r;
    r = $urandom_range(99);
    if (r < 18) return CMD_INS_HEAD;
    if (r < 36) return CMD_INS_TAIL;
    if (r < 50) return CMD_DEL_POS;
    if (r < 58) return CMD_DEL_TAIL;
    if (r < 66) return CMD_DEL_HEAD;
    if (r < 80) return CMD_SEARCH;
    if (r < 95) return CMD_LIST;
    return CMD_UNUSED;
  endfunction

  // Offer one request at the falling edge and hold it until accepted
  task automatic send_request(input logic [CMD_W-1:0] cmd, input logic [VALUE_W-1:0] value,
                              input logic [POS_W-1:0] pos, output list_result_t first_res);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= cmd;
    in_tdata  <= {{(40 - VALUE_W - POS_W){1'b0}}, pos, value};
    do @(posedge clk); while (!in_tready);
    predict_request(cmd, value, pos, first_res);
    if (cmd != CMD_UNUSED) requests_sent++;
  endtask

  // Fill the list, push past full, then list and search it
  task automatic fill_list();
    list_result_t dummy;
    while (list_len < CAPACITY)
      send_request($urandom_range(1) ? CMD_INS_HEAD : CMD_INS_TAIL, pick_value(),
                   pick_position(), dummy);
    repeat ($urandom_range(2, 1))
      send_request($urandom_range(1) ? CMD_INS_HEAD : CMD_INS_TAIL, $urandom,
                   POS_W'($urandom_range(15)), dummy);
    send_request(CMD_LIST, $urandom, POS_W'($urandom_range(15)), dummy);
    send_request(CMD_SEARCH, list_vals[$urandom_range(CAPACITY - 1)],
                 POS_W'($urandom_range(15)), dummy);
  endtask

  task automatic run_episode();
    list_result_t dummy;
    int r;
    r = $urandom_range(9);
    if (r < 2) begin
      fill_list();
    end else if (r == 2) begin
      // drain to empty, then one delete too many
      while (list_len > 0) send_request(pick_delete(), $urandom, pick_position(), dummy);
      send_request(pick_delete(), $urandom, POS_W'($urandom_range(15)), dummy);
    end else begin
      send_request(pick_command(), pick_value(), pick_position(), dummy);
    end
  endtask

  // Stop offering and wait until every queued result has arrived
  task automatic wait_for_results();
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  // Receiver: random stall, or a long hold-off when one is asked for
  initial begin : drive_ready
    int hold_left;
    hold_left  = 0;
    out_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_seen != hold_asks) begin
        hold_seen = hold_asks;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        out_tready <= 1'b0;
        hold_left--;
      end else begin
        out_tready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  function automatic void check_field(input string name, input logic [VALUE_W-1:0] want,
                                      input logic [VALUE_W-1:0] got);
    if (got !== want) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      mismatches++;
    end
  endfunction

  // Compare each accepted result with the oldest expectation
  always @(posedge clk) begin : check_results
    list_result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_results.size() == 0) begin
        $error("result with no request waiting: status %0h, tdata %0h", out_tuser, out_tdata);
        mismatches++;
      end else begin
        want = pending_results.pop_front();
        results_seen++;
        check_field("status", VALUE_W'(want.status), VALUE_W'(out_tuser));
        check_field("found", VALUE_W'(want.found), VALUE_W'(out_tdata[0]));
        check_field("entry_value", want.entry_value, out_tdata[32:1]);
        check_field("last", VALUE_W'(want.is_last), VALUE_W'(out_tlast));
        check_field("length", VALUE_W'(want.length), VALUE_W'(out_tdata[37:33]));
      end
    end
  end

  initial begin : watchdog
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("timeout with %0d results outstanding", pending_results.size());
    $display("testbench failed");
    $finish;
  end

  initial begin : main_flow
    list_result_t first_res;
    int i;
    int phase;
    int start;
    rst_n     = 1'b0;
    in_tvalid = 1'b0;
    in_tdata  = '0;
    in_tuser  = '0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed table
    for (i = 0; i < NUM_ROWS; i++) begin
      send_request(directed_rows[i].cmd, directed_rows[i].value, directed_rows[i].pos,
                   first_res);
      if (directed_rows[i].typed && (first_res.status !== directed_rows[i].status ||
                                     first_res.length !== directed_rows[i].length)) begin
        $error("row %0d: expected status %0d length %0d, model gives %0d %0d", i,
               directed_rows[i].status, directed_rows[i].length,
               first_res.status, first_res.length);
        mismatches++;
      end
    end
    wait_for_results();

    // Back-pressure: receiver holds off while a full fill and two lists go in
    hold_asks++;
    fill_list();
    send_request(CMD_LIST, '0, '0, first_res);
    send_request(CMD_LIST, '0, '0, first_res);
    wait_for_results();

    // Random traffic under each idling pattern
    for (phase = 0; phase < 4; phase++) begin
      send_idle_pct  = idle_pct_by_phase[phase];
      recv_stall_pct = stall_pct_by_phase[phase];
      start = requests_sent;
      while (requests_sent - start < PHASE_ITEMS) run_episode();
      wait_for_results();
    end

    // Let any stray result show up
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("ran %0d requests, checked %0d results over four idle/stall patterns",
             requests_sent, results_seen);
    $display("refused inserts %0d, peak length %0d", refused_inserts, peak_len);
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("testbench passed");
    end else begin
      $display("testbench failed");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/core/olist_pkg.sv
rtl/core/olist_ctrl.sv
rtl/core/olist_dp.sv
rtl/core/ordered_list_engine.sv
tb/testbench.sv
